[rtl/assert_macros.svh]
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never hold outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/abba_pkg.sv]
// Shared constants, types and codes of the aligned bitmap block allocator.
package abba_pkg;

    localparam int TOTAL_BLOCKS = 4096;
    localparam int WORD_BITS    = 64;
    localparam int NUM_WORDS    = TOTAL_BLOCKS / WORD_BITS;
    localparam int IDX_W        = 12;
    localparam int CNT_W        = 13;
    localparam int BIT_W        = 6;
    localparam int WADDR_W      = 6;
    localparam int PTR_W        = 7;

    localparam logic OP_RESERVE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_ZERO_COUNT = 2'd1,
        ST_NO_SPACE   = 2'd2
    } t_status;

    typedef struct packed {
        logic               operation;
        logic [CNT_W-1:0]   block_count;
        logic [CNT_W-1:0]   alignment;
        logic [IDX_W-1:0]   release_start;
    } t_cmd;

    typedef struct packed {
        t_status            status;
        logic [IDX_W-1:0]   start_index;
    } t_result;

    typedef struct packed {
        logic                 rd_en;
        logic [WADDR_W-1:0]   rd_addr;
        logic                 wr_en;
        logic [WADDR_W-1:0]   wr_addr;
        logic [WORD_BITS-1:0] wr_data;
    } t_map_req;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_BIT,
        S_MOD_RD,
        S_MOD_WR,
        S_PTR_RD,
        S_PTR_CHK
    } t_state;

endpackage

[rtl/aligned_bitmap_block_allocator_core.sv]
// Top level of the aligned bitmap block allocator: command sequencer over the free map.
//
// One command is taken when start is high and busy is low; its single result
// appears on o_result for one cycle with o_valid high and cannot be held off.
// A release reads and rewrites each bitmap word it touches. A reserve scans the
// free map one block per cycle from block 0, pausing in S_SCAN_RD to fetch each
// 64-block word, until the end of the first fitting aligned run or, for a miss, the
// end of the map; it then reads and rewrites each word of the run and advances the
// lowest-free-word pointer past words with no free block. The single map RAM read
// port and the one-block-per-cycle scan set this pace. A zero-count reserve or a
// zero-count release answers in the cycle after the transfer.
module aligned_bitmap_block_allocator_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  abba_pkg::t_cmd    i_cmd,
    output logic              busy,
    output logic              o_valid,
    output abba_pkg::t_result o_result
);
    import abba_pkg::*;

    `include "assert_macros.svh"

    t_state               r_state, n_state;
    t_cmd                 r_cmd, n_cmd;
    logic [IDX_W-1:0]     r_pos, n_pos;
    logic [CNT_W-1:0]     r_mod, n_mod;
    logic [CNT_W-1:0]     r_align_m1, n_align_m1;
    logic [IDX_W-1:0]     r_cand, n_cand;
    logic                 r_cand_v, n_cand_v;
    logic [CNT_W-1:0]     r_len, n_len;
    logic [IDX_W-1:0]     r_lo, n_lo;
    logic [IDX_W-1:0]     r_hi, n_hi;
    logic [WADDR_W-1:0]   r_word, n_word;
    logic [PTR_W-1:0]     r_ptr, n_ptr;
    logic                 r_valid, n_valid;
    t_result              r_result, n_result;

    t_map_req             map_req;
    logic [WORD_BITS-1:0] map_q;

    logic                 bit_free;
    logic                 run_ok;
    logic [CNT_W-1:0]     len_inc;
    logic                 hit;
    logic                 last_pos;
    logic                 last_word;
    logic [BIT_W-1:0]     lo_b, hi_b;
    logic [WORD_BITS-1:0] mask;
    logic [IDX_W+1:0]     rel_end;

    abba_map u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (map_req),
        .o_rd_word (map_q)
    );

    // Scan decisions for the current block.
    assign bit_free  = map_q[r_pos[BIT_W-1:0]];
    assign run_ok    = bit_free && (r_cand_v || (r_mod == '0));
    assign len_inc   = r_cand_v ? r_len + CNT_W'(1) : CNT_W'(1);
    assign hit       = run_ok && (len_inc == r_cmd.block_count);
    assign last_pos  = (r_pos == IDX_W'(TOTAL_BLOCKS - 1));
    assign last_word = (r_word == r_hi[IDX_W-1:BIT_W]);

    // Bit mask of the range [r_lo, r_hi] within the current word.
    assign lo_b = (r_word == r_lo[IDX_W-1:BIT_W]) ? r_lo[BIT_W-1:0] : '0;
    assign hi_b = last_word ? r_hi[BIT_W-1:0] : BIT_W'(WORD_BITS - 1);
    assign mask = ({WORD_BITS{1'b1}} << lo_b)
                & ({WORD_BITS{1'b1}} >> (BIT_W'(WORD_BITS - 1) - hi_b));

    // One past the last released block, before clipping.
    assign rel_end = {2'b00, i_cmd.release_start} + {1'b0, i_cmd.block_count};

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_cmd.block_count == '0) begin
                        n_state = S_IDLE;
                    end else if (i_cmd.operation == OP_RESERVE) begin
                        n_state = S_SCAN_RD;
                    end else begin
                        n_state = S_MOD_RD;
                    end
                end
            end
            S_SCAN_RD: n_state = S_SCAN_BIT;
            S_SCAN_BIT: begin
                if (hit) begin
                    n_state = S_MOD_RD;
                end else if (last_pos) begin
                    n_state = S_IDLE;
                end else if (r_pos[BIT_W-1:0] == BIT_W'(WORD_BITS - 1)) begin
                    n_state = S_SCAN_RD;
                end
            end
            S_MOD_RD: n_state = S_MOD_WR;
            S_MOD_WR: begin
                if (!last_word) begin
                    n_state = S_MOD_RD;
                end else if (r_cmd.operation == OP_RELEASE) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PTR_RD;
                end
            end
            S_PTR_RD: begin
                if (r_ptr == PTR_W'(NUM_WORDS)) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PTR_CHK;
                end
            end
            S_PTR_CHK: begin
                if (map_q != '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_PTR_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath updates and map requests.
    always_comb begin
        n_cmd      = r_cmd;
        n_pos      = r_pos;
        n_mod      = r_mod;
        n_align_m1 = r_align_m1;
        n_cand     = r_cand;
        n_cand_v   = r_cand_v;
        n_len      = r_len;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_word     = r_word;
        n_ptr      = r_ptr;
        n_valid    = 1'b0;
        n_result   = r_result;
        map_req    = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_cmd = i_cmd;
                    if (i_cmd.block_count == '0) begin
                        // Zero count: reserve is rejected, release does nothing.
                        n_valid  = 1'b1;
                        n_result = (i_cmd.operation == OP_RESERVE) ?
                                   {ST_ZERO_COUNT, IDX_W'(0)} : {ST_OK, IDX_W'(0)};
                    end else if (i_cmd.operation == OP_RESERVE) begin
                        n_pos      = '0;
                        n_mod      = '0;
                        n_cand_v   = 1'b0;
                        n_len      = '0;
                        n_align_m1 = (i_cmd.alignment == '0) ? '0
                                   : i_cmd.alignment - CNT_W'(1);
                    end else begin
                        n_lo   = i_cmd.release_start;
                        n_hi   = (rel_end > (IDX_W+2)'(TOTAL_BLOCKS)) ?
                                 IDX_W'(TOTAL_BLOCKS - 1) : IDX_W'(rel_end - (IDX_W+2)'(1));
                        n_word = i_cmd.release_start[IDX_W-1:BIT_W];
                        if (PTR_W'(i_cmd.release_start[IDX_W-1:BIT_W]) < r_ptr) begin
                            n_ptr = PTR_W'(i_cmd.release_start[IDX_W-1:BIT_W]);
                        end
                    end
                end
            end
            S_SCAN_RD: begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = r_pos[IDX_W-1:BIT_W];
            end
            S_SCAN_BIT: begin
                // Track the lowest aligned start of the current free run.
                if (!bit_free) begin
                    n_cand_v = 1'b0;
                end else if (r_cand_v) begin
                    n_len = len_inc;
                end else if (r_mod == '0) begin
                    n_cand_v = 1'b1;
                    n_cand   = r_pos;
                    n_len    = CNT_W'(1);
                end
                n_mod = (r_mod == r_align_m1) ? '0 : r_mod + CNT_W'(1);
                n_pos = r_pos + IDX_W'(1);
                if (hit) begin
                    n_lo   = r_cand_v ? r_cand : r_pos;
                    n_hi   = r_pos;
                    n_word = r_cand_v ? r_cand[IDX_W-1:BIT_W] : r_pos[IDX_W-1:BIT_W];
                end else if (last_pos) begin
                    n_valid  = 1'b1;
                    n_result = {ST_NO_SPACE, IDX_W'(0)};
                end
            end
            S_MOD_RD: begin
                map_req.rd_en   = 1'b1;
                map_req.rd_addr = r_word;
            end
            S_MOD_WR: begin
                map_req.wr_en   = 1'b1;
                map_req.wr_addr = r_word;
                map_req.wr_data = (r_cmd.operation == OP_RELEASE) ?
                                  (map_q | mask) : (map_q & ~mask);
                if (!last_word) begin
                    n_word = r_word + WADDR_W'(1);
                end else if (r_cmd.operation == OP_RELEASE) begin
                    n_valid  = 1'b1;
                    n_result = {ST_OK, IDX_W'(0)};
                end
            end
            S_PTR_RD: begin
                if (r_ptr == PTR_W'(NUM_WORDS)) begin
                    n_valid  = 1'b1;
                    n_result = {ST_OK, r_lo};
                end else begin
                    map_req.rd_en   = 1'b1;
                    map_req.rd_addr = r_ptr[WADDR_W-1:0];
                end
            end
            S_PTR_CHK: begin
                // Pointer stops at the first word that still has a free block.
                if (map_q != '0) begin
                    n_valid  = 1'b1;
                    n_result = {ST_OK, r_lo};
                end else begin
                    n_ptr = r_ptr + PTR_W'(1);
                end
            end
            default: begin
                n_valid = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ptr    <= '0;
            r_valid  <= 1'b0;
            r_cand_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_valid  <= n_valid;
            r_cand_v <= n_cand_v;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_pos      <= n_pos;
        r_mod      <= n_mod;
        r_align_m1 <= n_align_m1;
        r_cand     <= n_cand;
        r_len      <= n_len;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_word     <= n_word;
        r_result   <= n_result;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_result = r_result;

    `ASSERT_CLK(a_result_when_idle, i_clk, i_rst_n, o_valid |-> !busy,
                "result shown while busy")
    `ASSERT_NEVER(a_no_write_in_scan, i_clk, i_rst_n,
                  (r_state == S_SCAN_BIT) && map_req.wr_en, "map written during scan")
    `ASSERT_CLK(a_fail_start_zero, i_clk, i_rst_n,
                (o_valid && (o_result.status != ST_OK)) |-> (o_result.start_index == '0),
                "failed reserve carries a start index")
    `ASSERT_CLK(a_ptr_bound, i_clk, i_rst_n, r_ptr <= PTR_W'(NUM_WORDS),
                "pointer beyond word count")

endmodule

[rtl/abba_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module abba_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[rtl/abba_map.sv]
// Free map storage: word RAM plus per-word written flags that give the all-free reset image.
module abba_map (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  abba_pkg::t_map_req                i_req,
    output logic [abba_pkg::WORD_BITS-1:0]    o_rd_word
);
    import abba_pkg::*;

    logic [NUM_WORDS-1:0] r_written;
    logic                 r_rd_written;
    logic [WORD_BITS-1:0] ram_q;

    abba_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_req.wr_en),
        .i_wr_addr (i_req.wr_addr),
        .i_wr_data (i_req.wr_data),
        .i_rd_en   (i_req.rd_en),
        .i_rd_addr (i_req.rd_addr),
        .o_rd_data (ram_q)
    );

    // A word never written since reset reads as fully free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_written    <= '0;
            r_rd_written <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_written[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_written <= r_written[i_req.rd_addr];
            end
        end
    end

    assign o_rd_word = r_rd_written ? ram_q : {WORD_BITS{1'b1}};

endmodule

[tb/sv/tb_top.sv]
// Self-checking testbench of the aligned bitmap block allocator core.
`timescale 1ns / 100ps

module tb_top;
    import abba_pkg::*;

    // One pending command with its lead-in gap and an optional drain hold-off.
    typedef struct {
        t_cmd cmd;
        int   gap;
        bit   drain;
    } t_pending;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd    i_cmd = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    t_pending pending_cmds[$];
    t_result  expected_results[$];
    int       mismatch_count = 0;
    bit       stimulus_done = 1'b0;

    // Predicted free map: one bit per block, 1 means free.
    bit free_blk[TOTAL_BLOCKS];
    int low_word;

    aligned_bitmap_block_allocator_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_cmd   (i_cmd),
        .busy    (busy),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic bit word_empty(int w);
        for (int k = 0; k < WORD_BITS; k++) begin
            if (free_blk[w * WORD_BITS + k]) begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    function automatic void skip_empty_words();
        while (low_word < NUM_WORDS && word_empty(low_word)) begin
            low_word++;
        end
    endfunction

    function automatic int round_up(int v, int a);
        return ((v + a - 1) / a) * a;
    endfunction

    // First-fit aligned search; clears the run it finds.
    function automatic t_result predict_reserve(int n, int a);
        t_result r;
        int      s;
        int      blocker;
        bit      hit;
        r = '{status: ST_OK, start_index: '0};
        if (n == 0) begin
            r.status = ST_ZERO_COUNT;
            return r;
        end
        if (a == 0) begin
            a = 1;
        end
        skip_empty_words();
        if (low_word >= NUM_WORDS || n > TOTAL_BLOCKS) begin
            r.status = ST_NO_SPACE;
            return r;
        end
        s = low_word * WORD_BITS;
        while (!free_blk[s]) begin
            s++;
        end
        s = round_up(s, a);
        while (s + n <= TOTAL_BLOCKS) begin
            hit = 1'b0;
            blocker = 0;
            for (int k = n - 1; k >= 0; k--) begin
                if (!free_blk[s + k]) begin
                    blocker = s + k;
                    hit = 1'b1;
                    break;
                end
            end
            if (!hit) begin
                for (int k = 0; k < n; k++) begin
                    free_blk[s + k] = 1'b0;
                end
                r.start_index = s[IDX_W-1:0];
                skip_empty_words();
                return r;
            end
            s = round_up(blocker + 1, a);
        end
        r.status = ST_NO_SPACE;
        return r;
    endfunction

    // Release is clipped at the end of the map and lowers the pointer.
    function automatic void predict_release(int from, int n);
        if (from >= TOTAL_BLOCKS) begin
            return;
        end
        if (n > TOTAL_BLOCKS - from) begin
            n = TOTAL_BLOCKS - from;
        end
        if (n == 0) begin
            return;
        end
        for (int k = 0; k < n; k++) begin
            free_blk[from + k] = 1'b1;
        end
        if (from / WORD_BITS < low_word) begin
            low_word = from / WORD_BITS;
        end
    endfunction

    function automatic t_result predict_result(t_cmd c);
        if (c.operation == OP_RESERVE) begin
            return predict_reserve(int'(c.block_count), int'(c.alignment));
        end
        predict_release(int'(c.release_start), int'(c.block_count));
        return '{status: ST_OK, start_index: '0};
    endfunction

    function automatic void add_cmd(logic op, int n, int a, int from, int gap, bit drain);
        t_pending p;
        p.cmd.operation     = op;
        p.cmd.block_count   = n[CNT_W-1:0];
        p.cmd.alignment     = a[CNT_W-1:0];
        p.cmd.release_start = from[IDX_W-1:0];
        p.gap   = gap;
        p.drain = drain;
        pending_cmds.push_back(p);
    endfunction

    // Driver: present commands one by one, predict each on its transfer.
    t_pending cur;
    bit       loaded = 1'b0;
    bit       presenting = 1'b0;
    int       wait_left = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            presenting = 1'b0;
        end else begin
            if (start && !busy) begin
                expected_results.push_back(predict_result(i_cmd));
                presenting = 1'b0;
                loaded = 1'b0;
            end
            if (!loaded && pending_cmds.size() > 0) begin
                cur = pending_cmds.pop_front();
                wait_left = cur.gap;
                loaded = 1'b1;
            end
            if (loaded && !presenting) begin
                if (wait_left > 0) begin
                    wait_left--;
                end else if (!cur.drain || expected_results.size() == 0) begin
                    presenting = 1'b1;
                end
            end
            start <= presenting;
            if (presenting) begin
                i_cmd <= cur.cmd;
            end
        end
    end

    // Monitor: every strobed result is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) begin
                    $display("unexpected result: status %0d start %0d",
                             o_result.status, o_result.start_index);
                end
            end else begin
                want = expected_results.pop_front();
                if (o_result.status !== want.status ||
                    o_result.start_index !== want.start_index) begin
                    mismatch_count++;
                    if (mismatch_count <= 10) begin
                        $display({"result mismatch: expected status %0d start %0d, ",
                                  "got status %0d start %0d"},
                                 want.status, want.start_index,
                                 o_result.status, o_result.start_index);
                    end
                end
            end
        end
    end

    // Stimulus: directed corner cases, then a random mix.
    initial begin
        int  op_pick;
        int  n;
        int  a;
        int  gap;
        bit  burst;
        for (int k = 0; k < TOTAL_BLOCKS; k++) begin
            free_blk[k] = 1'b1;
        end
        low_word = 0;

        // Zero count, zero alignment, widest alignment and oversized requests.
        add_cmd(OP_RESERVE, 0, 1, 0, 0, 1'b0);
        add_cmd(OP_RESERVE, 1, 0, 4095, 3, 1'b0);
        add_cmd(OP_RESERVE, 1, 4096, 0, 0, 1'b0);
        add_cmd(OP_RESERVE, 3, 8191, 0, 0, 1'b0);
        add_cmd(OP_RESERVE, 4097, 1, 0, 1, 1'b0);
        add_cmd(OP_RESERVE, 8191, 1, 0, 0, 1'b0);
        add_cmd(OP_RESERVE, 70, 64, 0, 0, 1'b0);
        add_cmd(OP_RESERVE, 5, 3, 0, 0, 1'b0);
        // Release past the end, of zero blocks, and of already free blocks.
        add_cmd(OP_RELEASE, 8191, 1, 4095, 0, 1'b0);
        add_cmd(OP_RELEASE, 0, 8191, 4095, 2, 1'b0);
        add_cmd(OP_RELEASE, 10, 1, 3000, 0, 1'b0);
        add_cmd(OP_RELEASE, 4096, 1, 0, 0, 1'b1);
        // Full map, then a single hole.
        add_cmd(OP_RESERVE, 4096, 1, 0, 0, 1'b0);
        add_cmd(OP_RESERVE, 1, 1, 0, 0, 1'b0);
        add_cmd(OP_RELEASE, 1, 1, 100, 5, 1'b0);
        add_cmd(OP_RESERVE, 1, 1, 0, 0, 1'b0);
        add_cmd(OP_RELEASE, 4096, 1, 0, 0, 1'b0);
        add_cmd(OP_RESERVE, 64, 4096, 0, 0, 1'b0);
        add_cmd(OP_RESERVE, 65, 1, 0, 0, 1'b0);
        add_cmd(OP_RELEASE, 4096, 1, 0, 0, 1'b0);

        burst = 1'b0;
        for (int i = 0; i < 750; i++) begin
            if (i % 40 == 0) begin
                burst = ($urandom_range(0, 2) == 0);
            end
            gap = burst ? 0 : $urandom_range(0, 18);
            op_pick = $urandom_range(0, 99);
            if (op_pick < 50) begin
                // Typical reserve: mostly small run, power-of-two or small (0 to 9) alignment.
                n = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 600) : $urandom_range(1, 64);
                a = ($urandom_range(0, 1) == 0) ? (1 << $urandom_range(0, 7)) : $urandom_range(0, 9);
                add_cmd(OP_RESERVE, n, a, $urandom_range(0, 4095), gap, 1'b0);
            end else if (op_pick < 88) begin
                // Release of a random range, sometimes clipped at the end.
                add_cmd(OP_RELEASE, $urandom_range(1, 160), $urandom_range(0, 8191),
                        $urandom_range(0, 4095), gap, 1'b0);
            end else if (op_pick < 90) begin
                add_cmd(OP_RELEASE, 4096, $urandom_range(0, 8191), 0, gap, 1'b0);
            end else begin
                // Noise across the full width of every field.
                add_cmd($urandom_range(0, 1), $urandom_range(0, 8191), $urandom_range(0, 8191),
                        $urandom_range(0, 4095), gap, (i % 150 == 75));
            end
        end
        stimulus_done = 1'b1;
    end

    // Reset, then wait for every transfer and every result.
    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        while (!stimulus_done || pending_cmds.size() > 0 || loaded ||
               expected_results.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    // Timeout far beyond the slowest correct run.
    initial begin
        #100ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

[aligned_bitmap_block_allocator_core.f]
+incdir+rtl
rtl/abba_pkg.sv
rtl/abba_ram.sv
rtl/abba_map.sv
rtl/aligned_bitmap_block_allocator_core.sv
tb/sv/tb_top.sv
